[rtl/kos_pkg.sv]
// Shared constants, types and the LFSR step of the knockout output-queued switch.
// Used by kos_mod_unit and knockout_output_queued_switch; depends on nothing.
package kos_pkg;

    localparam int PORTS       = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int PORT_W  = $clog2(PORTS);
    localparam int CNT_W   = $clog2(PORTS + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = PORTS * QUEUE_DEPTH;
    localparam int MEM_AW  = $clog2(MEM_DEPTH);

    localparam int K_W     = 4;
    localparam int BUF_W   = 5;
    localparam int SLOT_W  = 16;
    localparam int LFSR_W  = 32;
    localparam int DEST_W  = 3;
    localparam int SRC_W   = 3;
    localparam int DELAY_W = 5;
    localparam int LOST_W  = 4;
    localparam int VALID_W = 8;
    localparam int DESTS_W = 24;

    localparam logic [LFSR_W-1:0] LFSR_MASK = 32'hD000_0001;
    localparam logic [LFSR_W-1:0] SEED_RESET = 32'd1;
    localparam logic [K_W-1:0]    K_RESET    = 4'd4;
    localparam logic [BUF_W-1:0]  BUF_RESET  = 5'd4;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 24;
    localparam int OUT_PAD_W = OUT_W - (PORT_W + 1 + SRC_W + DELAY_W + 1 + LOST_W);

    typedef enum logic [1:0] {
        REG_K_LIMIT      = 2'd0,
        REG_BUFFER_LIMIT = 2'd1,
        REG_LFSR_SEED    = 2'd2
    } reg_index_t;

    // Input transaction, last field in the low bits.
    typedef struct packed {
        logic [DESTS_W-1:0] arrival_dest;
        logic [VALID_W-1:0] arrival_valid;
    } arrival_t;

    // Result transaction, last field in the low bits.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [LOST_W-1:0]    buffer_lost;
        logic                 knocked_out;
        logic [DELAY_W-1:0]   delay;
        logic [SRC_W-1:0]     source_port;
        logic                 sent;
        logic [PORT_W-1:0]    out_port;
    } result_t;

    typedef logic [PORTS-1:0][PORT_W-1:0] src_list_t;

    typedef struct packed {
        logic              start;
        logic [LFSR_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [PORT_W-1:0] rem;
    } mod_resp_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] state);
        logic [LFSR_W-1:0] shifted;
        shifted = state >> 1;
        if (state[0])
        begin
            shifted = shifted ^ LFSR_MASK;
        end
        return shifted;
    endfunction

endpackage

[rtl/kos_mod_unit.sv]
// Bit-serial remainder unit: random word modulo a small contender count.
// Depends on kos_pkg for widths and the request/response structs.
module kos_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  kos_pkg::mod_req_t  req,
    output kos_pkg::mod_resp_t resp
);

    localparam int BIT_W = $clog2(kos_pkg::LFSR_W);
    localparam int T_W   = kos_pkg::CNT_W + 1;

    logic                         busy_reg;
    logic                         done_reg;
    logic [kos_pkg::LFSR_W-1:0]   shift_reg;
    logic [kos_pkg::PORT_W-1:0]   rem_reg;
    logic [kos_pkg::CNT_W-1:0]    divisor_reg;
    logic [BIT_W-1:0]             bit_cnt_reg;

    logic [T_W-1:0] trial;
    logic [T_W-1:0] reduced;

    // Shift one dividend bit into the partial remainder, subtract when it fits.
    always_comb
    begin
        trial = T_W'({rem_reg, shift_reg[kos_pkg::LFSR_W-1]});
        if (trial >= T_W'(divisor_reg))
        begin
            reduced = trial - T_W'(divisor_reg);
        end
        else
        begin
            reduced = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_W'(kos_pkg::LFSR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg   <= req.dividend;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= reduced[kos_pkg::PORT_W-1:0];
        end
    end

    assign resp.done = done_reg;
    assign resp.rem  = rem_reg;

endmodule

[rtl/knockout_output_queued_switch.sv]
// Knockout output-queued switch: one time slot per input transaction, one result per port.
// Per port: gather, check the count against k with one knockout at a time, one enqueue per
// survivor plus a closing step, then the result; a slot is first accepted while idle.
// One slot at a time; a removal is one LFSR step plus the 32-bit serial modulo.
// Reset: async active low; queues empty, slot counter zero, limits 4/4, LFSR state and seed 1.
// Depends on kos_pkg and kos_mod_unit.
module knockout_output_queued_switch (
    input  logic                          clk,
    input  logic                          rst_n,

    // Input slot stream. tdata: arrival_valid[7:0], arrival_dest[31:8]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [kos_pkg::IN_W-1:0]      s_axis_tdata,

    // Result stream. tdata: out_port[2:0], sent[3], source_port[6:4], delay[11:7],
    // knocked_out[12], buffer_lost[16:13], zero pad[23:17]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [kos_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                          m_axis_tlast,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kos_pkg::PADDR_W-1:0]   paddr,
    input  logic [kos_pkg::PDATA_W-1:0]   pwdata,
    output logic [kos_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_CHECK,
        ST_MOD,
        ST_ENQ,
        ST_RESULT
    } state_t;

    localparam int KCMP_W = (kos_pkg::CNT_W > kos_pkg::K_W) ? kos_pkg::CNT_W : kos_pkg::K_W;
    localparam int LIM_W  = (kos_pkg::QCNT_W > kos_pkg::BUF_W) ? kos_pkg::QCNT_W
                                                               : kos_pkg::BUF_W;
    localparam int POS_W  = kos_pkg::QCNT_W + 1;
    localparam int ENTRY_W = kos_pkg::PORT_W + kos_pkg::SLOT_W;

    typedef logic [kos_pkg::PORTS-1:0][kos_pkg::QCNT_W-1:0] qcount_arr_t;
    typedef logic [kos_pkg::PORTS-1:0][kos_pkg::QPTR_W-1:0] qhead_arr_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                          state_reg,    state_next;
    kos_pkg::arrival_t               in_reg,       in_next;
    logic [kos_pkg::PORT_W-1:0]      port_reg,     port_next;
    kos_pkg::src_list_t              list_reg,     list_next;
    logic [kos_pkg::CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [kos_pkg::CNT_W-1:0]       enq_idx_reg,  enq_idx_next;
    logic                            knocked_reg,  knocked_next;
    logic [kos_pkg::LOST_W-1:0]      lost_reg,     lost_next;
    qcount_arr_t                     qcount_reg,   qcount_next;
    qhead_arr_t                      qhead_reg,    qhead_next;
    logic [kos_pkg::SLOT_W-1:0]      slot_reg,     slot_next;
    logic [kos_pkg::LFSR_W-1:0]      random_reg,   random_next;
    logic [kos_pkg::K_W-1:0]         k_limit_reg,  k_limit_next;
    logic [kos_pkg::BUF_W-1:0]       buf_limit_reg, buf_limit_next;
    logic [kos_pkg::LFSR_W-1:0]      seed_reg,     seed_next;
    logic                            out_valid_reg, out_valid_next;
    kos_pkg::result_t                out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;

    // Queue storage: source port and arrival slot per entry, one ring per output port.
    logic [ENTRY_W-1:0]              queue_mem [kos_pkg::MEM_DEPTH];
    logic [ENTRY_W-1:0]              mem_rd_reg;
    logic                            mem_we;
    logic [kos_pkg::MEM_AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]              mem_wdata;
    logic [kos_pkg::MEM_AW-1:0]      mem_raddr;

    // Shared modulo unit
    kos_pkg::mod_req_t               mod_req;
    kos_pkg::mod_resp_t              mod_resp;

    // Combinational helpers
    kos_pkg::src_list_t              gather_list;
    logic [kos_pkg::CNT_W-1:0]       gather_cnt;
    kos_pkg::src_list_t              removed_list;
    logic                            over_limit;
    logic [LIM_W-1:0]                limit_eff;
    logic [kos_pkg::QCNT_W-1:0]      qcount_cur;
    logic [kos_pkg::QPTR_W-1:0]      qhead_cur;
    logic [POS_W-1:0]                tail_sum;
    logic [kos_pkg::QPTR_W-1:0]      tail_pos;
    logic [kos_pkg::QPTR_W-1:0]      head_inc;
    logic [kos_pkg::LFSR_W-1:0]      random_adv;
    logic [kos_pkg::SLOT_W-1:0]      delay_full;
    logic [kos_pkg::DELAY_W-1:0]     delay_sat;
    logic                            cfg_write;
    logic [kos_pkg::LFSR_W-1:0]      seed_load;

    kos_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .resp  (mod_resp)
    );

    // ---------------------------------------------------------------
    // Contender list: inputs addressed to the current port, ascending input order.
    // ---------------------------------------------------------------
    always_comb
    begin
        gather_list = '0;
        gather_cnt  = '0;
        for (int p = 0; p < kos_pkg::PORTS; p++)
        begin
            if (in_reg.arrival_valid[p] &&
                in_reg.arrival_dest[p*kos_pkg::DEST_W +: kos_pkg::DEST_W] ==
                kos_pkg::DEST_W'(port_reg))
            begin
                gather_list[gather_cnt[kos_pkg::PORT_W-1:0]] = kos_pkg::PORT_W'(p);
                gather_cnt = gather_cnt + 1'b1;
            end
        end
    end

    // Knock out the contender at the remainder index: close the gap above it.
    always_comb
    begin
        removed_list = list_reg;
        for (int i = 0; i < kos_pkg::PORTS - 1; i++)
        begin
            if (kos_pkg::PORT_W'(i) >= mod_resp.rem)
            begin
                removed_list[i] = list_reg[i+1];
            end
        end
    end

    // Queue bookkeeping for the port in service.
    always_comb
    begin
        over_limit = KCMP_W'(cnt_reg) > KCMP_W'(k_limit_reg);
        // An occupancy limit above the storage acts as the storage depth.
        if (LIM_W'(buf_limit_reg) > LIM_W'(kos_pkg::QUEUE_DEPTH))
        begin
            limit_eff = LIM_W'(kos_pkg::QUEUE_DEPTH);
        end
        else
        begin
            limit_eff = LIM_W'(buf_limit_reg);
        end
        qcount_cur = qcount_reg[port_reg];
        qhead_cur  = qhead_reg[port_reg];
        tail_sum   = POS_W'(qhead_cur) + POS_W'(qcount_cur);
        if (tail_sum >= POS_W'(kos_pkg::QUEUE_DEPTH))
        begin
            tail_pos = kos_pkg::QPTR_W'(tail_sum - POS_W'(kos_pkg::QUEUE_DEPTH));
        end
        else
        begin
            tail_pos = kos_pkg::QPTR_W'(tail_sum);
        end
        if (qhead_cur == kos_pkg::QPTR_W'(kos_pkg::QUEUE_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = qhead_cur + 1'b1;
        end
        mem_raddr = kos_pkg::MEM_AW'(port_reg) * kos_pkg::MEM_AW'(kos_pkg::QUEUE_DEPTH)
                  + kos_pkg::MEM_AW'(qhead_cur);
        random_adv = kos_pkg::lfsr_next(random_reg);
        // Delay wraps in slot-counter width, then saturates to the result field.
        delay_full = kos_pkg::SLOT_W'(slot_reg + kos_pkg::SLOT_W'(1)
                   - mem_rd_reg[kos_pkg::SLOT_W-1:0]);
        if (delay_full > kos_pkg::SLOT_W'({kos_pkg::DELAY_W{1'b1}}))
        begin
            delay_sat = {kos_pkg::DELAY_W{1'b1}};
        end
        else
        begin
            delay_sat = delay_full[kos_pkg::DELAY_W-1:0];
        end
        cfg_write = psel && penable && pwrite;
        seed_load = (pwdata == '0) ? kos_pkg::SEED_RESET : pwdata;
    end

    // ---------------------------------------------------------------
    // Slot sequencer. Per port: gather contenders, knock out one at a time
    // through the modulo unit, enqueue survivors one per cycle (counting as lost
    // those that find the queue full), then pop the head into the output register.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        port_next      = port_reg;
        list_next      = list_reg;
        cnt_next       = cnt_reg;
        enq_idx_next   = enq_idx_reg;
        knocked_next   = knocked_reg;
        lost_next      = lost_reg;
        qcount_next    = qcount_reg;
        qhead_next     = qhead_reg;
        slot_next      = slot_reg;
        random_next    = random_reg;
        k_limit_next   = k_limit_reg;
        buf_limit_next = buf_limit_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = kos_pkg::MEM_AW'(port_reg) * kos_pkg::MEM_AW'(kos_pkg::QUEUE_DEPTH)
                       + kos_pkg::MEM_AW'(tail_pos);
        mem_wdata      = {list_reg[enq_idx_reg[kos_pkg::PORT_W-1:0]], slot_reg};
        mod_req        = '0;

        // Drop the held result once the downstream side takes it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next    = kos_pkg::arrival_t'(s_axis_tdata);
                    port_next  = '0;
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                list_next    = gather_list;
                cnt_next     = gather_cnt;
                knocked_next = 1'b0;
                lost_next    = '0;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (over_limit)
                begin
                    // Advance the LFSR and reduce its new value modulo the count.
                    knocked_next     = 1'b1;
                    random_next      = random_adv;
                    mod_req.start    = 1'b1;
                    mod_req.dividend = random_adv;
                    mod_req.divisor  = cnt_reg;
                    state_next       = ST_MOD;
                end
                else
                begin
                    enq_idx_next = '0;
                    state_next   = ST_ENQ;
                end
            end
            ST_MOD:
            begin
                if (mod_resp.done)
                begin
                    list_next  = removed_list;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_ENQ:
            begin
                if (enq_idx_reg < cnt_reg)
                begin
                    if (LIM_W'(qcount_cur) < limit_eff)
                    begin
                        mem_we                = 1'b1;
                        qcount_next[port_reg] = qcount_cur + 1'b1;
                    end
                    else if (lost_reg != {kos_pkg::LOST_W{1'b1}})
                    begin
                        lost_next = lost_reg + 1'b1;
                    end
                    enq_idx_next = enq_idx_reg + 1'b1;
                end
                else
                begin
                    // The head read issues in this cycle; data is ready next cycle.
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next               = '0;
                    out_data_next.out_port      = port_reg;
                    out_data_next.knocked_out   = knocked_reg;
                    out_data_next.buffer_lost   = lost_reg;
                    out_last_next = (port_reg == kos_pkg::PORT_W'(kos_pkg::PORTS - 1));
                    if (qcount_cur != '0)
                    begin
                        out_data_next.sent        = 1'b1;
                        out_data_next.source_port =
                            kos_pkg::SRC_W'(mem_rd_reg[ENTRY_W-1:kos_pkg::SLOT_W]);
                        out_data_next.delay       = delay_sat;
                        qhead_next[port_reg]      = head_inc;
                        qcount_next[port_reg]     = qcount_cur - 1'b1;
                    end
                    if (port_reg == kos_pkg::PORT_W'(kos_pkg::PORTS - 1))
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        port_next  = port_reg + 1'b1;
                        state_next = ST_GATHER;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must arrive only while the sequencer is idle; the block itself does not enforce it.
        if (cfg_write)
        begin
            case (kos_pkg::reg_index_t'(paddr[3:2]))
                kos_pkg::REG_K_LIMIT:
                begin
                    k_limit_next = pwdata[kos_pkg::K_W-1:0];
                end
                kos_pkg::REG_BUFFER_LIMIT:
                begin
                    buf_limit_next = pwdata[kos_pkg::BUF_W-1:0];
                end
                kos_pkg::REG_LFSR_SEED:
                begin
                    seed_next   = pwdata;
                    random_next = seed_load;
                end
                default:
                begin
                    seed_next = seed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            port_reg      <= '0;
            cnt_reg       <= '0;
            enq_idx_reg   <= '0;
            knocked_reg   <= 1'b0;
            lost_reg      <= '0;
            qcount_reg    <= '0;
            qhead_reg     <= '0;
            slot_reg      <= '0;
            random_reg    <= kos_pkg::SEED_RESET;
            k_limit_reg   <= kos_pkg::K_RESET;
            buf_limit_reg <= kos_pkg::BUF_RESET;
            seed_reg      <= kos_pkg::SEED_RESET;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            port_reg      <= port_next;
            cnt_reg       <= cnt_next;
            enq_idx_reg   <= enq_idx_next;
            knocked_reg   <= knocked_next;
            lost_reg      <= lost_next;
            qcount_reg    <= qcount_next;
            qhead_reg     <= qhead_next;
            slot_reg      <= slot_next;
            random_reg    <= random_next;
            k_limit_reg   <= k_limit_next;
            buf_limit_reg <= buf_limit_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        list_reg     <= list_next;
        out_data_reg <= out_data_next;
    end

    // Queue memory: one write port, one registered read port at the serviced head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= queue_mem[mem_raddr];
    end

    // Register readback
    always_comb
    begin
        case (kos_pkg::reg_index_t'(paddr[3:2]))
            kos_pkg::REG_K_LIMIT:      prdata = kos_pkg::PDATA_W'(k_limit_reg);
            kos_pkg::REG_BUFFER_LIMIT: prdata = kos_pkg::PDATA_W'(buf_limit_reg);
            kos_pkg::REG_LFSR_SEED:    prdata = seed_reg;
            default:                   prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the knockout output-queued switch.
// Drives slot transactions and APB register writes, predicts every port result
// in-house and checks it field by field; depends on kos_pkg and the switch RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kos_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int LONG_HOLD = 600;
    localparam int MAX_REPORTS = 10;
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

    // One expected port result together with its tlast flag.
    typedef struct packed {
        logic    last;
        result_t res;
    } port_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;    // arrival_valid[7:0], arrival_dest[31:8]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;         // out_port, sent, source_port, delay,
                                              // knocked_out, buffer_lost, zero pad
    logic               m_axis_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    knockout_output_queued_switch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow registers and switch state kept by the predictor.
    logic [K_W-1:0]     k_shadow = 4'd4;
    logic [BUF_W-1:0]   occ_limit = 5'd4;
    logic [LFSR_W-1:0]  seed_shadow = 32'd1;
    logic [LFSR_W-1:0]  knock_rng = 32'd1;
    logic [SLOT_W-1:0]  slot_now = '0;
    logic [SRC_W-1:0]   fifo_src [PORTS][QUEUE_DEPTH];
    logic [SLOT_W-1:0]  fifo_arrival [PORTS][QUEUE_DEPTH];
    int                 fifo_fill [PORTS];
    int                 fifo_head [PORTS];

    arrival_t           slot_pending [$];
    port_result_t       port_results_due [$];
    int                 slots_queued = 0;
    int                 slots_taken = 0;
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 sender_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_request = 0;
    int                 hold_left = 0;
    logic               in_taken = 1'b0;

    initial
    begin
        for (int p = 0; p < PORTS; p++)
        begin
            fifo_fill[p] = 0;
            fifo_head[p] = 0;
        end
    end

    // Free-running clock, 10 ns period.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, port_results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [LFSR_W-1:0] knock_step(input logic [LFSR_W-1:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

    // Work out one slot: knockout per port, enqueue survivors, pop each head.
    task automatic predict_slot(input arrival_t a);
        logic [SRC_W-1:0] contenders [PORTS];
        logic [SLOT_W-1:0] dl;
        port_result_t pr;
        int cnt;
        int lost;
        int idx;
        int pos;
        int lim;
        int keep;
        logic knocked;
        lim = (occ_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(occ_limit);
        keep = int'(k_shadow);
        for (int port = 0; port < PORTS; port++)
        begin
            cnt = 0;
            lost = 0;
            // List contenders in ascending input-port order.
            for (int p = 0; p < PORTS; p++)
            begin
                if (a.arrival_valid[p] && a.arrival_dest[3*p +: 3] == port)
                begin
                    contenders[cnt] = SRC_W'(p);
                    cnt++;
                end
            end
            knocked = (cnt > keep);
            // Knock out one contender per LFSR advance until k remain.
            while (cnt > keep)
            begin
                knock_rng = knock_step(knock_rng);
                idx = int'(knock_rng % LFSR_W'(cnt));
                for (int i = idx; i + 1 < cnt; i++)
                begin
                    contenders[i] = contenders[i + 1];
                end
                cnt--;
            end
            // Survivors join the FIFO while it has room under the limit.
            for (int i = 0; i < cnt; i++)
            begin
                if (fifo_fill[port] < lim)
                begin
                    pos = (fifo_head[port] + fifo_fill[port]) % QUEUE_DEPTH;
                    fifo_src[port][pos] = contenders[i];
                    fifo_arrival[port][pos] = slot_now;
                    fifo_fill[port]++;
                end
                else
                begin
                    lost++;
                end
            end
            pr = '0;
            pr.res.out_port = PORT_W'(port);
            if (fifo_fill[port] > 0)
            begin
                dl = slot_now + 16'd1 - fifo_arrival[port][fifo_head[port]];
                pr.res.sent = 1'b1;
                pr.res.source_port = fifo_src[port][fifo_head[port]];
                pr.res.delay = (dl > 31) ? 5'd31 : dl[DELAY_W-1:0];
                fifo_head[port] = (fifo_head[port] + 1) % QUEUE_DEPTH;
                fifo_fill[port]--;
            end
            pr.res.knocked_out = knocked;
            pr.res.buffer_lost = (lost > 15) ? 4'd15 : LOST_W'(lost);
            pr.last = (port == PORTS - 1);
            port_results_due = {port_results_due, pr};
        end
        slot_now = slot_now + 16'd1;
    endtask

    task automatic note_mismatch(input string what, input port_result_t want,
                                 input port_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t %s: exp port=%0d sent=%0d src=%0d delay=%0d ko=%0d lost=%0d pad=%0h last=%0d",
                     $realtime, what, want.res.out_port, want.res.sent, want.res.source_port,
                     want.res.delay, want.res.knocked_out, want.res.buffer_lost, want.res.pad,
                     want.last);
            $display("      got port=%0d sent=%0d src=%0d delay=%0d ko=%0d lost=%0d pad=%0h last=%0d",
                     got.res.out_port, got.res.sent, got.res.source_port, got.res.delay,
                     got.res.knocked_out, got.res.buffer_lost, got.res.pad, got.last);
        end
    endtask

    // Compare one accepted result transaction with the oldest expectation.
    task automatic check_port_result(input port_result_t got);
        port_result_t want;
        logic bad;
        if (port_results_due.size() == 0)
        begin
            note_mismatch("result with nothing pending", '0, got);
            return;
        end
        want = port_results_due.pop_front();
        bad = 1'b0;
        if (got.res.out_port    !== want.res.out_port)    bad = 1'b1;
        if (got.res.sent        !== want.res.sent)        bad = 1'b1;
        if (got.res.source_port !== want.res.source_port) bad = 1'b1;
        if (got.res.delay       !== want.res.delay)       bad = 1'b1;
        if (got.res.knocked_out !== want.res.knocked_out) bad = 1'b1;
        if (got.res.buffer_lost !== want.res.buffer_lost) bad = 1'b1;
        if (got.res.pad         !== want.res.pad)         bad = 1'b1;
        if (got.last            !== want.last)            bad = 1'b1;
        if (bad)
        begin
            note_mismatch("port result mismatch", want, got);
        end
    endtask

    // Monitor: sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_slot(arrival_t'(s_axis_tdata));
            slots_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_port_result({m_axis_tlast, result_t'(m_axis_tdata)});
        end
    end

    // Driver: advance to the next pending slot once the current one is taken,
    // inserting random idle cycles between transactions.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || in_taken)
        begin
            if (slot_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= slot_pending.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [PADDR_W-1:0] reg_addr(input reg_index_t r);
        return PADDR_W'({r, 2'b00});
    endfunction

    // APB write: setup cycle, access cycle, register taken at the access edge.
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr[3:2])
            REG_K_LIMIT:      k_shadow = val[K_W-1:0];
            REG_BUFFER_LIMIT: occ_limit = val[BUF_W-1:0];
            REG_LFSR_SEED:
            begin
                // Seed write reloads the LFSR; a zero seed loads one.
                seed_shadow = val;
                knock_rng = (val == '0) ? 32'd1 : val;
            end
            default: ;
        endcase
    endtask

    task automatic reg_read_check(input reg_index_t r, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= reg_addr(r);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t register %s read: exp %0h got %0h", $realtime, r.name(), want, got);
            end
        end
    endtask

    task automatic check_registers();
        reg_read_check(REG_K_LIMIT, PDATA_W'(k_shadow));
        reg_read_check(REG_BUFFER_LIMIT, PDATA_W'(occ_limit));
        reg_read_check(REG_LFSR_SEED, seed_shadow);
    endtask

    task automatic configure(input logic [K_W-1:0] k, input logic [BUF_W-1:0] lim,
                             input logic [LFSR_W-1:0] seed);
        reg_write(reg_addr(REG_K_LIMIT), PDATA_W'(k));
        reg_write(reg_addr(REG_BUFFER_LIMIT), PDATA_W'(lim));
        reg_write(reg_addr(REG_LFSR_SEED), seed);
        check_registers();
    endtask

    task automatic queue_slot(input logic [VALID_W-1:0] v, input logic [DESTS_W-1:0] d);
        arrival_t a;
        a.arrival_valid = v;
        a.arrival_dest = d;
        slot_pending = {slot_pending, a};
        slots_queued++;
    endtask

    // Hold until every slot is taken and every port result has come back.
    task automatic wait_drained();
        do @(negedge clk); while (slots_taken != slots_queued || port_results_due.size() != 0);
    endtask

    // Random slot: mostly hotspot and full-load traffic to push knockout and
    // queue overflow, some uniform noise and some sparse slots.
    task automatic queue_random_slot(input logic [2:0] hot);
        logic [VALID_W-1:0] v;
        logic [DESTS_W-1:0] d;
        int kind;
        kind = $urandom_range(99);
        v = VALID_W'($urandom());
        d = DESTS_W'($urandom());
        if (kind < 40)
        begin
            v = v | VALID_W'($urandom());
            for (int p = 0; p < PORTS; p++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    d[3*p +: 3] = hot;
                end
            end
        end
        else if (kind < 55)
        begin
            v = '1;
        end
        else if (kind < 85)
        begin
            // uniform noise, keep as drawn
        end
        else if (kind < 95)
        begin
            v = VALID_W'(1) << $urandom_range(PORTS - 1);
        end
        else
        begin
            v = '0;
        end
        queue_slot(v, d);
    endtask

    task automatic random_phase(input int n_slots, input int idle, input int stall,
                                input bit long_hold);
        logic [K_W-1:0] k;
        logic [BUF_W-1:0] lim;
        logic [2:0] hot;
        k = ($urandom_range(99) < 25) ? K_W'($urandom_range(15)) : K_W'($urandom_range(1, 8));
        lim = ($urandom_range(99) < 25) ? BUF_W'($urandom_range(31))
                                        : BUF_W'($urandom_range(1, 16));
        configure(k, lim, LFSR_W'($urandom()));
        sender_idle_pct = idle;
        recv_stall_pct = stall;
        hot = 3'($urandom_range(7));
        for (int i = 0; i < n_slots; i++)
        begin
            if ($urandom_range(99) < 10)
            begin
                hot = 3'($urandom_range(7));
            end
            queue_random_slot(hot);
        end
        if (long_hold)
        begin
            // Back-pressure the output long enough that the input stalls.
            hold_request = LONG_HOLD;
        end
        wait_drained();
    endtask

    localparam logic [DESTS_W-1:0] DEST_IDENTITY =
        {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [DESTS_W-1:0] DEST_REVERSED =
        {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values, then the default configuration: empty slot, full
        // contention on one port at either end, a permutation each way, one lone input at each end.
        check_registers();
        queue_slot(8'h00, DEST_REVERSED);
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'hFF, 24'hFFFFFF);
        queue_slot(8'hFF, DEST_IDENTITY);
        queue_slot(8'hFF, DEST_REVERSED);
        queue_slot(8'h01, 24'h000000);
        queue_slot(8'h80, 24'hFFFFFF);
        wait_drained();

        // Zero k_limit: every contender knocked out.
        configure(4'd0, 5'd16, 32'h0000_0001);
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'hFF, DEST_IDENTITY);
        queue_slot(8'h5A, DEST_REVERSED);
        queue_slot(8'hA5, 24'hFFFFFF);
        wait_drained();

        // No knockout, limit above storage, zero seed; fill one FIFO and
        // drain it with empty slots so the delay climbs.
        configure(4'd8, 5'd31, 32'h0000_0000);
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'h00, 24'h000000);
        queue_slot(8'h00, 24'h000000);
        queue_slot(8'h00, 24'hFFFFFF);
        wait_drained();

        // Largest k_limit, zero occupancy limit: every survivor lost.
        configure(4'd15, 5'd0, 32'hFFFF_FFFF);
        queue_slot(8'hFF, {8{3'd3}});
        queue_slot(8'hFF, DEST_IDENTITY);
        wait_drained();

        // Tightest useful limits; an unmapped register write changes nothing.
        configure(4'd1, 5'd1, 32'h8000_0000);
        reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
        check_registers();
        queue_slot(8'hFF, 24'h000000);
        queue_slot(8'hFF, DEST_IDENTITY);
        wait_drained();

        // Random traffic under each idling mix.
        random_phase(55, 0, 0, 1'b1);
        random_phase(55, 48, 0, 1'b0);
        random_phase(55, 0, 48, 1'b0);
        random_phase(55, 34, 34, 1'b0);
        random_phase(10, 0, 0, 1'b0);

        // Let any stray result surface before deciding.
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && port_results_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[knockout_output_queued_switch.f]
rtl/kos_pkg.sv
rtl/kos_mod_unit.sv
rtl/knockout_output_queued_switch.sv
verif/testbench.sv
